/* hw/rtl/rpn_stack_calculator_macros.svh */
// assertion macros used by the calculator top level
`ifndef RPN_STACK_CALCULATOR_MACROS_SVH
`define RPN_STACK_CALCULATOR_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define RPN_CHK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define RPN_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/rpn_pkg.sv */
// types, codes and microprogram of the rpn calculator
`default_nettype none

package rpn_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int VAR_COUNT_DEF   = 16;
    localparam int WORD_W          = 32;
    localparam int ENTRY_W         = WORD_W + 1;
    localparam int STEP_W          = 5;

    // token actions
    localparam logic [2:0] ACT_PUSH_VAL = 3'd0;
    localparam logic [2:0] ACT_PUSH_VAR = 3'd1;
    localparam logic [2:0] ACT_OPER     = 3'd2;
    localparam logic [2:0] ACT_PRINT    = 3'd3;
    localparam logic [2:0] ACT_ASSIGN   = 3'd4;

    // operator codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_UNF    = 3'd1,
        ST_OVF    = 3'd2,
        ST_DIVZ   = 3'd3,
        ST_UNDEF  = 3'd4,
        ST_BADASG = 3'd5
    } t_status;

    // datapath micro-operations
    typedef enum logic [3:0] {
        U_NOP,
        U_FETCH,
        U_PUSH,
        U_RD_TOP,
        U_LATCH_A,
        U_LATCH_A_RD2,
        U_LATCH_B,
        U_RESOLVE_A,
        U_RESOLVE_B,
        U_PRINT,
        U_DIV_START,
        U_DIV_WB,
        U_ALU_WB,
        U_ASSIGN,
        U_SET_STATUS,
        U_EMIT
    } t_uop;

    // sequencing: next, goto, branch if cond, hold while cond, dispatch on action
    typedef enum logic [2:0] {
        J_NEXT,
        J_GOTO,
        J_IF,
        J_WAIT,
        J_DISPATCH
    } t_jmp;

    typedef enum logic [3:0] {
        C_NONE,
        C_FULL,
        C_LT1,
        C_LT2,
        C_A_BAD,
        C_B_BAD,
        C_DIV_ZERO,
        C_NOT_DIV,
        C_DIV_BUSY,
        C_BAD_ASG,
        C_OUT_BUSY
    } t_cond;

    typedef logic [STEP_W-1:0] t_step;

    typedef struct packed {
        t_uop    uop;
        t_jmp    jmp;
        t_cond   cond;
        t_step   target;
        t_status status;
    } t_uword;

    // condition flags from the datapath
    typedef struct packed {
        logic full;
        logic lt1;
        logic lt2;
        logic a_bad;
        logic b_bad;
        logic div_zero;
        logic not_div;
        logic div_busy;
        logic bad_asg;
        logic out_busy;
    } t_flags;

    // program addresses
    localparam t_step S_FETCH   = 5'd0;
    localparam t_step S_PUSH    = 5'd1;
    localparam t_step S_PUSH_WR = 5'd2;
    localparam t_step S_PRINT   = 5'd3;
    localparam t_step S_PR_RD   = 5'd4;
    localparam t_step S_PR_LA   = 5'd5;
    localparam t_step S_PR_SYM  = 5'd6;
    localparam t_step S_PR_RES  = 5'd7;
    localparam t_step S_PR_OUT  = 5'd8;
    localparam t_step S_OPER    = 5'd9;
    localparam t_step S_OP_RD   = 5'd10;
    localparam t_step S_OP_LA   = 5'd11;
    localparam t_step S_OP_LB   = 5'd12;
    localparam t_step S_OP_RA   = 5'd13;
    localparam t_step S_OP_RB   = 5'd14;
    localparam t_step S_OP_DZ   = 5'd15;
    localparam t_step S_OP_SEL  = 5'd16;
    localparam t_step S_OP_DWT  = 5'd17;
    localparam t_step S_OP_DWB  = 5'd18;
    localparam t_step S_OP_ALU  = 5'd19;
    localparam t_step S_ASG     = 5'd20;
    localparam t_step S_AS_RD   = 5'd21;
    localparam t_step S_AS_LA   = 5'd22;
    localparam t_step S_AS_LB   = 5'd23;
    localparam t_step S_AS_CHK  = 5'd24;
    localparam t_step S_AS_WR   = 5'd25;
    localparam t_step S_UNF     = 5'd26;
    localparam t_step S_OVF     = 5'd27;
    localparam t_step S_UNDEF   = 5'd28;
    localparam t_step S_DZ      = 5'd29;
    localparam t_step S_BADASG  = 5'd30;
    localparam t_step S_EMIT    = 5'd31;

    function automatic t_uword mk_uw(input t_uop u, input t_jmp j, input t_cond c,
                                     input t_step t, input t_status s);
        t_uword w;
        w.uop    = u;
        w.jmp    = j;
        w.cond   = c;
        w.target = t;
        w.status = s;
        return w;
    endfunction

    // microprogram rom
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        unique case (s)
            S_FETCH:   w = mk_uw(U_FETCH,       J_DISPATCH, C_NONE,     S_FETCH,  ST_OK);
            S_PUSH:    w = mk_uw(U_NOP,         J_IF,       C_FULL,     S_OVF,    ST_OK);
            S_PUSH_WR: w = mk_uw(U_PUSH,        J_GOTO,     C_NONE,     S_EMIT,   ST_OK);
            S_PRINT:   w = mk_uw(U_NOP,         J_IF,       C_LT1,      S_UNF,    ST_OK);
            S_PR_RD:   w = mk_uw(U_RD_TOP,      J_NEXT,     C_NONE,     S_FETCH,  ST_OK);
            S_PR_LA:   w = mk_uw(U_LATCH_A,     J_NEXT,     C_NONE,     S_FETCH,  ST_OK);
            S_PR_SYM:  w = mk_uw(U_NOP,         J_NEXT,     C_NONE,     S_FETCH,  ST_OK);
            S_PR_RES:  w = mk_uw(U_RESOLVE_A,   J_IF,       C_A_BAD,    S_UNDEF,  ST_OK);
            S_PR_OUT:  w = mk_uw(U_PRINT,       J_GOTO,     C_NONE,     S_EMIT,   ST_OK);
            S_OPER:    w = mk_uw(U_NOP,         J_IF,       C_LT2,      S_UNF,    ST_OK);
            S_OP_RD:   w = mk_uw(U_RD_TOP,      J_NEXT,     C_NONE,     S_FETCH,  ST_OK);
            S_OP_LA:   w = mk_uw(U_LATCH_A_RD2, J_NEXT,     C_NONE,     S_FETCH,  ST_OK);
            S_OP_LB:   w = mk_uw(U_LATCH_B,     J_NEXT,     C_NONE,     S_FETCH,  ST_OK);
            S_OP_RA:   w = mk_uw(U_RESOLVE_A,   J_IF,       C_A_BAD,    S_UNDEF,  ST_OK);
            S_OP_RB:   w = mk_uw(U_RESOLVE_B,   J_IF,       C_B_BAD,    S_UNDEF,  ST_OK);
            S_OP_DZ:   w = mk_uw(U_NOP,         J_IF,       C_DIV_ZERO, S_DZ,     ST_OK);
            S_OP_SEL:  w = mk_uw(U_DIV_START,   J_IF,       C_NOT_DIV,  S_OP_ALU, ST_OK);
            S_OP_DWT:  w = mk_uw(U_NOP,         J_WAIT,     C_DIV_BUSY, S_OP_DWB, ST_OK);
            S_OP_DWB:  w = mk_uw(U_DIV_WB,      J_GOTO,     C_NONE,     S_EMIT,   ST_OK);
            S_OP_ALU:  w = mk_uw(U_ALU_WB,      J_GOTO,     C_NONE,     S_EMIT,   ST_OK);
            S_ASG:     w = mk_uw(U_NOP,         J_IF,       C_LT2,      S_UNF,    ST_OK);
            S_AS_RD:   w = mk_uw(U_RD_TOP,      J_NEXT,     C_NONE,     S_FETCH,  ST_OK);
            S_AS_LA:   w = mk_uw(U_LATCH_A_RD2, J_NEXT,     C_NONE,     S_FETCH,  ST_OK);
            S_AS_LB:   w = mk_uw(U_LATCH_B,     J_NEXT,     C_NONE,     S_FETCH,  ST_OK);
            S_AS_CHK:  w = mk_uw(U_NOP,         J_IF,       C_BAD_ASG,  S_BADASG, ST_OK);
            S_AS_WR:   w = mk_uw(U_ASSIGN,      J_GOTO,     C_NONE,     S_EMIT,   ST_OK);
            S_UNF:     w = mk_uw(U_SET_STATUS,  J_GOTO,     C_NONE,     S_EMIT,   ST_UNF);
            S_OVF:     w = mk_uw(U_SET_STATUS,  J_GOTO,     C_NONE,     S_EMIT,   ST_OVF);
            S_UNDEF:   w = mk_uw(U_SET_STATUS,  J_GOTO,     C_NONE,     S_EMIT,   ST_UNDEF);
            S_DZ:      w = mk_uw(U_SET_STATUS,  J_GOTO,     C_NONE,     S_EMIT,   ST_DIVZ);
            S_BADASG:  w = mk_uw(U_SET_STATUS,  J_GOTO,     C_NONE,     S_EMIT,   ST_BADASG);
            S_EMIT:    w = mk_uw(U_EMIT,        J_WAIT,     C_OUT_BUSY, S_FETCH,  ST_OK);
            default:   w = mk_uw(U_NOP,         J_GOTO,     C_NONE,     S_FETCH,  ST_OK);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/rpn_if.sv */
// token and result channel interfaces
`default_nettype none

interface rpn_tok_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  action;
    logic signed [31:0] literal;
    logic        [3:0]  var_slot;
    logic        [1:0]  op_code;

    modport source (output valid, action, literal, var_slot, op_code, input ready);
    modport sink   (input valid, action, literal, var_slot, op_code, output ready);
endinterface

interface rpn_res_if;
    logic               valid;
    logic               ready;
    logic               printed;
    logic signed [31:0] print_value;
    logic        [2:0]  status;

    modport source (output valid, printed, print_value, status, input ready);
    modport sink   (input valid, printed, print_value, status, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rpn_stack_calculator.sv */
// rpn calculator top level: datapath, stores, output register
//
// Tokens arrive on i_tok (valid/ready); each token gives exactly one result
// beat on o_res: printed flag, printed value and status code.
// A microcoded sequencer walks one token at a time through a short program
// that reads the operand stack and the symbol table (both single-port-read
// rams with registered data) and writes back.
// Ignored action codes go straight to loading the result; a divide waits
// for the divider, which retires one quotient bit per cycle.
// i_tok.ready is high only while the sequencer waits for a token.
// The result sits in an output register; the next token is taken while it
// waits, and the sequencer holds before loading a new result until the
// receiver has taken the previous one.
// Reset (synchronous, active low) empties the stack, marks every variable
// undefined and drops any pending result; the rams need no clearing.
`default_nettype none
`include "rpn_stack_calculator_macros.svh"

module rpn_stack_calculator #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
    parameter int VAR_COUNT   = rpn_pkg::VAR_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rpn_tok_if.sink    i_tok,
    rpn_res_if.source  o_res
);
    import rpn_pkg::*;

    localparam int SW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int VW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

    t_uword uw;
    t_flags flags;
    logic   fetch;
    logic   accept;

    // token and working registers
    logic [2:0]         r_action;
    logic [WORD_W-1:0]  r_lit;
    logic [3:0]         r_slot;
    logic [1:0]         r_op;
    logic [ENTRY_W-1:0] r_a;
    logic [ENTRY_W-1:0] r_b;
    logic [CW-1:0]      r_cnt;
    logic [VAR_COUNT-1:0] r_defined;
    t_status            r_status;
    logic               r_printed;
    logic [WORD_W-1:0]  r_value;
    logic               r_out_valid;

    // stores
    logic               stk_we;
    logic [SW-1:0]      stk_waddr;
    logic [ENTRY_W-1:0] stk_wdata;
    logic [SW-1:0]      stk_raddr;
    logic [ENTRY_W-1:0] stk_rdata;
    logic               sym_we;
    logic [VW-1:0]      sym_waddr;
    logic [WORD_W-1:0]  sym_wdata;
    logic [VW-1:0]      sym_raddr;
    logic [WORD_W-1:0]  sym_rdata;

    logic [SW-1:0]      top_addr;
    logic [SW-1:0]      second_addr;
    logic [ENTRY_W-1:0] push_entry;
    logic [WORD_W-1:0]  alu;
    logic [ENTRY_W-1:0] var_ent;
    logic [ENTRY_W-1:0] val_ent;
    logic               div_start;
    logic               div_busy;
    logic [WORD_W-1:0]  quotient;
    logic               out_busy;
    logic               emit_load;

    function automatic logic slot_bad(input logic [ENTRY_W-1:0] e,
                                      input logic [VAR_COUNT-1:0] def);
        logic over;
        over = (e[WORD_W-1:0] >= WORD_W'(VAR_COUNT));
        return e[WORD_W] && (over || !def[e[VW-1:0]]);
    endfunction

    assign accept = i_tok.valid && i_tok.ready;
    assign i_tok.ready = fetch;

    rpn_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_action (i_tok.action),
        .i_flags  (flags),
        .o_uw     (uw),
        .o_fetch  (fetch)
    );

    // stack addressing
    assign top_addr    = SW'(CW'(r_cnt - 1'b1));
    assign second_addr = SW'(CW'(r_cnt - 2'd2));
    assign stk_raddr   = (uw.uop == U_RD_TOP) ? top_addr : second_addr;
    assign push_entry  = (r_action == ACT_PUSH_VAR) ? {1'b1, 28'd0, r_slot} : {1'b0, r_lit};

    // combinational alu for add, sub and mul
    always_comb begin
        case (r_op)
            OP_ADD:  alu = r_b[WORD_W-1:0] + r_a[WORD_W-1:0];
            OP_SUB:  alu = r_b[WORD_W-1:0] - r_a[WORD_W-1:0];
            OP_MUL:  alu = WORD_W'(r_b[WORD_W-1:0] * r_a[WORD_W-1:0]);
            default: alu = '0;
        endcase
    end

    // stack write port
    always_comb begin
        stk_we    = 1'b0;
        stk_waddr = second_addr;
        stk_wdata = {1'b0, alu};
        case (uw.uop)
            U_PUSH: begin
                stk_we    = 1'b1;
                stk_waddr = SW'(r_cnt);
                stk_wdata = push_entry;
            end
            U_ALU_WB: begin
                stk_we = 1'b1;
            end
            U_DIV_WB: begin
                stk_we    = 1'b1;
                stk_wdata = {1'b0, quotient};
            end
            default: begin
                stk_we = 1'b0;
            end
        endcase
    end

    rpn_ram #(.WIDTH(ENTRY_W), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // assignment picks the variable entry and the value entry
    assign var_ent   = r_a[WORD_W] ? r_a : r_b;
    assign val_ent   = r_a[WORD_W] ? r_b : r_a;
    assign sym_we    = (uw.uop == U_ASSIGN);
    assign sym_waddr = var_ent[VW-1:0];
    assign sym_wdata = val_ent[WORD_W-1:0];
    assign sym_raddr = (uw.uop == U_RESOLVE_A) ? r_b[VW-1:0] : r_a[VW-1:0];

    rpn_ram #(.WIDTH(WORD_W), .DEPTH(VAR_COUNT)) u_symtab (
        .i_clk   (i_clk),
        .i_we    (sym_we),
        .i_waddr (sym_waddr),
        .i_wdata (sym_wdata),
        .i_raddr (sym_raddr),
        .o_rdata (sym_rdata)
    );

    // divider
    assign div_start = (uw.uop == U_DIV_START) && (r_op == OP_DIV);

    rpn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_b[WORD_W-1:0]),
        .i_divisor  (r_a[WORD_W-1:0]),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    // branch conditions
    assign out_busy = r_out_valid && !o_res.ready;
    always_comb begin
        flags.full     = (r_cnt >= CW'(STACK_DEPTH));
        flags.lt1      = (r_cnt == '0);
        flags.lt2      = (r_cnt < CW'(2));
        flags.a_bad    = slot_bad(r_a, r_defined);
        flags.b_bad    = slot_bad(r_b, r_defined);
        flags.div_zero = (r_op == OP_DIV) && (r_a[WORD_W-1:0] == '0);
        flags.not_div  = (r_op != OP_DIV);
        flags.div_busy = div_busy;
        flags.bad_asg  = (r_a[WORD_W] == r_b[WORD_W]) ||
                         (var_ent[WORD_W-1:0] >= WORD_W'(VAR_COUNT));
        flags.out_busy = out_busy;
    end

    // token capture and operand registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_tok.action;
            r_lit    <= i_tok.literal;
            r_slot   <= i_tok.var_slot;
            r_op     <= i_tok.op_code;
        end
        case (uw.uop) inside
            U_LATCH_A, U_LATCH_A_RD2: r_a <= stk_rdata;
            U_LATCH_B:                r_b <= stk_rdata;
            U_RESOLVE_A: begin
                if (r_a[WORD_W]) begin
                    r_a <= {1'b0, sym_rdata};
                end
            end
            U_RESOLVE_B: begin
                if (r_b[WORD_W]) begin
                    r_b <= {1'b0, sym_rdata};
                end
            end
            default: begin
            end
        endcase
    end

    // stack count and defined bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_defined <= '0;
        end else begin
            case (uw.uop) inside
                U_PUSH:             r_cnt <= CW'(r_cnt + 1'b1);
                U_PRINT:            r_cnt <= CW'(r_cnt - 1'b1);
                U_ALU_WB, U_DIV_WB: r_cnt <= CW'(r_cnt - 1'b1);
                U_ASSIGN: begin
                    r_cnt                <= CW'(r_cnt - 2'd2);
                    r_defined[sym_waddr] <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // per-token result fields
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status  <= ST_OK;
            r_printed <= 1'b0;
            r_value   <= '0;
        end else if (uw.uop == U_SET_STATUS) begin
            r_status <= uw.status;
        end else if (uw.uop == U_PRINT) begin
            r_printed <= 1'b1;
            r_value   <= r_a[WORD_W-1:0];
        end
    end

    // output register
    assign emit_load = (uw.uop == U_EMIT) && !out_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            o_res.printed     <= r_printed;
            o_res.print_value <= r_value;
            o_res.status      <= r_status;
        end
    end

    assign o_res.valid = r_out_valid;

    // checks
    `RPN_CHK_NOW(a_cnt_range, 1'b1, r_cnt <= CW'(STACK_DEPTH), "stack count beyond depth")
    `RPN_CHK_NOW(a_push_room, uw.uop == U_PUSH, r_cnt < CW'(STACK_DEPTH), "push into full stack")
    `RPN_CHK_NOW(a_div_idle, fetch, !div_busy, "divider busy while waiting for a token")
    `RPN_CHK_NEXT(a_def_set, sym_we, r_defined[$past(sym_waddr)], "assigned variable not marked")

endmodule

`default_nettype wire

/* hw/rtl/rpn_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none

module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/rpn_div.sv */
// iterative signed truncating divider, one quotient bit per cycle
`default_nettype none

module rpn_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [rpn_pkg::WORD_W-1:0] i_dividend,
    input  logic [rpn_pkg::WORD_W-1:0] i_divisor,
    output logic                     o_busy,
    output logic [rpn_pkg::WORD_W-1:0] o_quotient
);
    import rpn_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_q;
    logic [WORD_W-1:0] r_d;
    logic [WORD_W:0]   r_rem;
    logic              r_neg;

    logic [WORD_W:0]   rem_sh;
    logic [WORD_W+1:0] trial;
    logic              fits;

    // shift in the next dividend bit and try the subtract
    assign rem_sh = {r_rem[WORD_W-1:0], r_q[WORD_W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, r_d};
    assign fits   = !trial[WORD_W+1];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(WORD_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    // magnitudes in, one restoring step per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend[WORD_W-1] ? (WORD_W'(0) - i_dividend) : i_dividend;
            r_d   <= i_divisor[WORD_W-1]  ? (WORD_W'(0) - i_divisor)  : i_divisor;
            r_rem <= '0;
            r_neg <= i_dividend[WORD_W-1] ^ i_divisor[WORD_W-1];
        end else if (r_busy) begin
            r_rem <= fits ? trial[WORD_W:0] : rem_sh;
            r_q   <= {r_q[WORD_W-2:0], fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_neg ? (WORD_W'(0) - r_q) : r_q;

endmodule

`default_nettype wire

/* hw/rtl/rpn_seq.sv */
// microcode sequencer: step counter, program rom and branch logic
`default_nettype none

module rpn_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [2:0]      i_action,
    input  rpn_pkg::t_flags i_flags,
    output rpn_pkg::t_uword o_uw,
    output logic            o_fetch
);
    import rpn_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_step  step_inc;
    t_uword uw;
    logic   cond_true;
    t_step  dispatch;

    assign uw       = ucode(r_step);
    assign step_inc = STEP_W'(r_step + 1'b1);

    // condition select
    always_comb begin
        unique case (uw.cond)
            C_FULL:     cond_true = i_flags.full;
            C_LT1:      cond_true = i_flags.lt1;
            C_LT2:      cond_true = i_flags.lt2;
            C_A_BAD:    cond_true = i_flags.a_bad;
            C_B_BAD:    cond_true = i_flags.b_bad;
            C_DIV_ZERO: cond_true = i_flags.div_zero;
            C_NOT_DIV:  cond_true = i_flags.not_div;
            C_DIV_BUSY: cond_true = i_flags.div_busy;
            C_BAD_ASG:  cond_true = i_flags.bad_asg;
            C_OUT_BUSY: cond_true = i_flags.out_busy;
            default:    cond_true = 1'b0;
        endcase
    end

    // entry point per token action
    always_comb begin
        unique case (i_action) inside
            ACT_PUSH_VAL, ACT_PUSH_VAR: dispatch = S_PUSH;
            ACT_OPER:                   dispatch = S_OPER;
            ACT_PRINT:                  dispatch = S_PRINT;
            ACT_ASSIGN:                 dispatch = S_ASG;
            default:                    dispatch = S_EMIT;
        endcase
    end

    // next step
    always_comb begin
        unique case (uw.jmp)
            J_NEXT:     n_step = step_inc;
            J_GOTO:     n_step = uw.target;
            J_IF:       n_step = cond_true ? uw.target : step_inc;
            J_WAIT:     n_step = cond_true ? r_step : uw.target;
            J_DISPATCH: n_step = i_accept ? dispatch : r_step;
            default:    n_step = S_FETCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_uw    = uw;
    assign o_fetch = (uw.uop == U_FETCH);

endmodule

`default_nettype wire
